FILE: hdl/rlse_pkg.sv
// ----------------------------------------------------------------------------
// rlse_pkg
// Shared widths, constants and types of the three-slot LED bit encoder.
// ----------------------------------------------------------------------------
package rlse_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned BRIGHT_W    = 9;
  localparam int unsigned UNITY       = 256;
  localparam int unsigned COLOUR_BITS = 3 * CHAN_W;
  localparam int unsigned SLOT_W      = 3 * COLOUR_BITS;      // slots per pixel
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned PEND_W      = COLOUR_BITS;          // most slots left over
  localparam int unsigned BUF_W       = SLOT_W + PEND_W;
  localparam int unsigned REM_W       = $clog2(BUF_W + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  // one encoded pixel, handed from the front end to the packer
  typedef struct packed {
    logic [SLOT_W-1:0] slots;
    logic              last;
  } slot_entry_t;

endpackage

FILE: hdl/rlse_front.sv
// ----------------------------------------------------------------------------
// rlse_front
// Brightness scaling and expansion of each colour bit into three wire slots.
// ----------------------------------------------------------------------------
module rlse_front
  import rlse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                brightness_we_i,
  input  logic [BRIGHT_W-1:0] brightness_i,
  input  logic                push,
  output logic                full,
  input  logic [CHAN_W-1:0]   red_i,
  input  logic [CHAN_W-1:0]   green_i,
  input  logic [CHAN_W-1:0]   blue_i,
  input  logic                last_pixel_i,
  output logic                entry_valid_o,
  input  logic                entry_ready_i,
  output slot_entry_t         entry_o
);

  logic [BRIGHT_W-1:0]        bright_q;
  logic                       valid_q, valid_d;
  slot_entry_t                entry_q;
  logic [CHAN_W+BRIGHT_W-1:0] prod_r, prod_g, prod_b;
  logic [COLOUR_BITS-1:0]     grb;
  slot_entry_t                entry_new;
  logic                       take;

  assign prod_r = (CHAN_W+BRIGHT_W)'(red_i)   * (CHAN_W+BRIGHT_W)'(bright_q);
  assign prod_g = (CHAN_W+BRIGHT_W)'(green_i) * (CHAN_W+BRIGHT_W)'(bright_q);
  assign prod_b = (CHAN_W+BRIGHT_W)'(blue_i)  * (CHAN_W+BRIGHT_W)'(bright_q);

  // brightness is saturated at unity, so the scaled byte never overflows
  assign grb = {prod_g[CHAN_W+7:8], prod_r[CHAN_W+7:8], prod_b[CHAN_W+7:8]};

  always_comb begin
    for (int j = 0; j < COLOUR_BITS; j++) begin
      entry_new.slots[3*j+2] = 1'b1;
      entry_new.slots[3*j+1] = grb[j];
      entry_new.slots[3*j]   = 1'b0;
    end
    entry_new.last = last_pixel_i;
  end

  assign full          = valid_q && !entry_ready_i;
  assign take          = push && !full;
  assign entry_valid_o = valid_q;
  assign entry_o       = entry_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && entry_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_W'(UNITY);
      valid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (brightness_we_i) begin
        bright_q <= (brightness_i > BRIGHT_W'(UNITY)) ? BRIGHT_W'(UNITY) : brightness_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q <= entry_new;
    end
  end

endmodule

FILE: hdl/rlse_fifo.sv
// ----------------------------------------------------------------------------
// rlse_fifo
// Short queue of encoded pixels between the front end and the packer.
// ----------------------------------------------------------------------------
module rlse_fifo
  import rlse_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  output logic        wr_ready_o,
  input  slot_entry_t wr_data_i,
  output logic        rd_valid_o,
  input  logic        rd_ready_i,
  output slot_entry_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  slot_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_wr, do_rd;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: hdl/rlse_back.sv
// ----------------------------------------------------------------------------
// rlse_back
// Slot packer: cuts the slot stream into 32-slot words and flushes on frame end.
// ----------------------------------------------------------------------------
module rlse_back
  import rlse_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              entry_valid_i,
  output logic              entry_ready_o,
  input  slot_entry_t       entry_i,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] waveform_word_o,
  output logic              last_word_o
);

  // work_q holds the unsent slots left aligned, zeros below rem_q
  logic [BUF_W-1:0]  work_q, work_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic              busy_q, busy_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q;
  logic              out_last_q;
  logic              out_take, have_word, below_word, flush, emit, can_load, load;

  assign out_take   = !out_valid_q || pop;
  assign below_word = (rem_q < REM_W'(WORD_W));
  assign have_word  = busy_q && !below_word;
  assign flush      = busy_q && below_word && last_q;
  assign emit       = (have_word || flush) && out_take;
  assign can_load   = !busy_q || (below_word && !last_q);
  assign load       = can_load && entry_valid_i;

  assign entry_ready_o   = can_load;
  assign empty           = !out_valid_q;
  assign waveform_word_o = out_word_q;
  assign last_word_o     = out_last_q;

  always_comb begin
    work_d      = work_q;
    rem_d       = rem_q;
    busy_d      = busy_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      work_d      = work_q << WORD_W;
      if (have_word) begin
        rem_d = rem_q - REM_W'(WORD_W);
      end else begin
        rem_d  = '0;
        busy_d = 1'b0;
      end
    end else if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      // leftover slots stay on top, new pixel goes in just below them
      work_d = {work_q[BUF_W-1 -: PEND_W], {SLOT_W{1'b0}}}
             | ({entry_i.slots, {PEND_W{1'b0}}} >> rem_q);
      rem_d  = rem_q + REM_W'(SLOT_W);
      busy_d = 1'b1;
      last_d = entry_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= '0;
      rem_q       <= '0;
      busy_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      work_q      <= work_d;
      rem_q       <= rem_d;
      busy_q      <= busy_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q <= work_q[BUF_W-1 -: WORD_W];
      out_last_q <= flush;
    end
  end

endmodule

FILE: hdl/rgb_led_three_slot_bit_encoder.sv
// ----------------------------------------------------------------------------
// rgb_led_three_slot_bit_encoder
// Turns RGB pixels into 32-slot wire words for addressable LED strings.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a pixel (red, green, blue, last_pixel)
// is taken on a clock edge with push high and full low.
// Output side is a queue read port: the oldest word sits on waveform_word_o
// and last_word_o while empty is low and leaves on an edge with pop high.
// brightness_i is written on any edge with brightness_we_i high; values above
// 256 are held at 256. Write it only between frames.
// Each pixel gives 72 slots (110 per one bit, 100 per zero bit, GRB, MSB
// first). Full words go out as they fill; the last pixel of a frame also
// sends the zero-padded remainder, or a zero word if nothing is left over.
// A taken pixel passes the front-end register, the queue, the packer's work
// buffer and its output register before its first word shows. The packer
// sends one word per cycle while its output register is free or popped, and
// loads another pixel only once fewer than 32 slots are left and no flush is
// due; every fourth pixel of a run completes three words (24 slots left over).
// Reset clears the queue, the leftover slots and brightness (to unity).
// If the reader stops popping, the packer halts on its output register and
// the queue, then full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module rgb_led_three_slot_bit_encoder
  import rlse_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                brightness_we_i,
  input  logic [BRIGHT_W-1:0] brightness_i,
  input  logic                push,
  output logic                full,
  input  logic [CHAN_W-1:0]   red_i,
  input  logic [CHAN_W-1:0]   green_i,
  input  logic [CHAN_W-1:0]   blue_i,
  input  logic                last_pixel_i,
  output logic                empty,
  input  logic                pop,
  output logic [WORD_W-1:0]   waveform_word_o,
  output logic                last_word_o
);

  logic        fe_valid, fe_ready;
  slot_entry_t fe_entry;
  logic        be_valid, be_ready;
  slot_entry_t be_entry;

  rlse_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .brightness_we_i (brightness_we_i),
    .brightness_i    (brightness_i),
    .push            (push),
    .full            (full),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .last_pixel_i    (last_pixel_i),
    .entry_valid_o   (fe_valid),
    .entry_ready_i   (fe_ready),
    .entry_o         (fe_entry)
  );

  rlse_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_data_i  (fe_entry),
    .rd_valid_o (be_valid),
    .rd_ready_i (be_ready),
    .rd_data_o  (be_entry)
  );

  rlse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_valid_i   (be_valid),
    .entry_ready_o   (be_ready),
    .entry_i         (be_entry),
    .empty           (empty),
    .pop             (pop),
    .waveform_word_o (waveform_word_o),
    .last_word_o     (last_word_o)
  );

endmodule

FILE: hdl/rlse_chk.sv
// ----------------------------------------------------------------------------
// rlse_chk
// Port-level checks on the LED bit encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rlse_chk
  import rlse_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic [WORD_W-1:0] waveform_word_o,
  input logic              last_word_o
);

  // nothing to read while reset is held
  a_empty_in_reset : assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("word visible during reset");

  // a waiting word must not change under the reader
  a_word_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(waveform_word_o) && $stable(last_word_o)))
    else $error("waiting word changed");

  // every slot triple opens high, so a full word is never blank
  a_full_word_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_word_o) |-> (waveform_word_o != '0))
    else $error("full word is all zero");

  // at most 24 slots remain for the flush, the rest is padding
  a_flush_padded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_word_o) |-> (waveform_word_o[WORD_W-PEND_W-1:0] == '0))
    else $error("flush word not zero padded");

endmodule

bind rgb_led_three_slot_bit_encoder rlse_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .waveform_word_o (waveform_word_o),
  .last_word_o     (last_word_o)
);
